// ===== src/touch_button_hold_tap_classifier_macros.svh =====
// Assertion macros used by the classifier top level.
`ifndef TOUCH_BUTTON_HOLD_TAP_CLASSIFIER_MACROS_SVH
`define TOUCH_BUTTON_HOLD_TAP_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TBHTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBHTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tbhtc_pkg.sv =====
// Shared types and constants for the touch button hold/tap classifier.
package tbhtc_pkg;

  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned DISP_W    = 22;
  localparam int unsigned SLEEP_W   = 26;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 26;
  localparam int unsigned CODE_W    = 3;
  localparam int unsigned TAPS_W    = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD1   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD2   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD3   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD5   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISPOFF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP   = 3'd6;

  // Register reset values
  localparam logic [HOLD_W-1:0]  HOLD1_RST   = 16'd1000;
  localparam logic [HOLD_W-1:0]  HOLD2_RST   = 16'd2000;
  localparam logic [HOLD_W-1:0]  HOLD3_RST   = 16'd3000;
  localparam logic [HOLD_W-1:0]  HOLD5_RST   = 16'd5000;
  localparam logic [HOLD_W-1:0]  RELEASE_RST = 16'd250;
  localparam logic [DISP_W-1:0]  DISPOFF_RST = 22'd20000;
  localparam logic [SLEEP_W-1:0] SLEEP_RST   = 26'd300000;

  // Event codes
  localparam logic [CODE_W-1:0] EV_NONE  = 3'd0;
  localparam logic [CODE_W-1:0] EV_TAP   = 3'd1;
  localparam logic [CODE_W-1:0] EV_HOLD1 = 3'd2;
  localparam logic [CODE_W-1:0] EV_HOLD2 = 3'd3;
  localparam logic [CODE_W-1:0] EV_HOLD3 = 3'd4;
  localparam logic [CODE_W-1:0] EV_HOLD5 = 3'd5;

  typedef struct packed {
    logic touch_level;
    logic restart_all;
    logic restart_sleep;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] event_code;
    logic [TAPS_W-1:0] tap_total;
    logic              reset_request;
    logic              display_off_pulse;
    logic              display_wake_pulse;
    logic              sleep_pulse;
  } out_item_t;

  typedef struct packed {
    logic [HOLD_W-1:0]  hold1_ms;
    logic [HOLD_W-1:0]  hold2_ms;
    logic [HOLD_W-1:0]  hold3_ms;
    logic [HOLD_W-1:0]  hold5_ms;
    logic [HOLD_W-1:0]  release_ms;
    logic [DISP_W-1:0]  display_off_ms;
    logic [SLEEP_W-1:0] sleep_ms;
  } cfg_t;

  typedef struct packed {
    logic off;
    logic wake;
    logic sleep;
  } timer_pulse_t;

endpackage

// ===== src/touch_button_hold_tap_classifier.sv =====
// Top level: tick input register, classifier and timers, result register.
//
// Usage: send one item per millisecond tick on the in channel (valid/ready);
// each tick yields exactly one result on the out channel (valid/ready).
// Result fields: event_code (0 none, 1 tap burst, 2..5 hold levels),
// tap_total, reset_request, display-off, display-wake and sleep pulses.
// Registers are written through cfg_we_i/cfg_index_i/cfg_wdata_i, one per
// cycle, while no tick is in flight; indexes past the list are ignored.
// Path: a transferred tick is held in the input register, is classified
// from it combinationally and its result is taken into the result register.
// Throughput: one tick per cycle while out_ready_i takes results; the state
// update between the input and result registers sets this figure.
// Stall: while the result register is held, the input register still takes
// one more tick, and in_ready_o drops only when both are full.
// Reset: both registers empty, timing registers at their reset values, the
// countdowns loaded from the reset timeouts; the first result carries a
// display-wake pulse.
module touch_button_hold_tap_classifier
  import tbhtc_pkg::*;
#(
  parameter int unsigned TAP_COUNT_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i
);

`include "touch_button_hold_tap_classifier_macros.svh"

  localparam int unsigned TapW = (TAP_COUNT_BITS > TAPS_W) ? TAPS_W : TAP_COUNT_BITS;

  cfg_t         cfg_q;
  logic         in_valid_q;
  in_item_t     in_q;
  logic         out_valid_q;
  out_item_t    out_q, out_d;
  logic         advance;
  logic         burst;
  logic         swallow;
  timer_pulse_t pulse;
  logic [CODE_W-1:0] code;
  logic [TAPS_W-1:0] taps;
  logic              reset_req;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold1_ms       <= HOLD1_RST;
      cfg_q.hold2_ms       <= HOLD2_RST;
      cfg_q.hold3_ms       <= HOLD3_RST;
      cfg_q.hold5_ms       <= HOLD5_RST;
      cfg_q.release_ms     <= RELEASE_RST;
      cfg_q.display_off_ms <= DISPOFF_RST;
      cfg_q.sleep_ms       <= SLEEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_HOLD1:   cfg_q.hold1_ms       <= cfg_wdata_i[HOLD_W-1:0];
        REG_HOLD2:   cfg_q.hold2_ms       <= cfg_wdata_i[HOLD_W-1:0];
        REG_HOLD3:   cfg_q.hold3_ms       <= cfg_wdata_i[HOLD_W-1:0];
        REG_HOLD5:   cfg_q.hold5_ms       <= cfg_wdata_i[HOLD_W-1:0];
        REG_RELEASE: cfg_q.release_ms     <= cfg_wdata_i[HOLD_W-1:0];
        REG_DISPOFF: cfg_q.display_off_ms <= cfg_wdata_i[DISP_W-1:0];
        REG_SLEEP:   cfg_q.sleep_ms       <= cfg_wdata_i[SLEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance when a tick is held and the result slot is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
    if (advance) out_q <= out_d;
  end

  tbhtc_button #(
    .TapW(TapW)
  ) u_button (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .touch_i    (in_q.touch_level),
    .swallow_i  (swallow),
    .cfg_i      (cfg_q),
    .burst_o    (burst),
    .code_o     (code),
    .taps_o     (taps),
    .reset_req_o(reset_req)
  );

  tbhtc_timers u_timers (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .restart_all_i  (in_q.restart_all),
    .restart_sleep_i(in_q.restart_sleep),
    .burst_i        (burst),
    .cfg_i          (cfg_q),
    .swallow_o      (swallow),
    .pulse_o        (pulse)
  );

  always_comb begin
    out_d.event_code         = code;
    out_d.tap_total          = taps;
    out_d.reset_request      = reset_req;
    out_d.display_off_pulse  = pulse.off;
    out_d.display_wake_pulse = pulse.wake;
    out_d.sleep_pulse        = pulse.sleep;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TBHTC_ASSERT_IMP(a_rst_req_hold5, clk_i, rst_ni,
    out_valid_o && out_data_o.reset_request, out_data_o.event_code == EV_HOLD5,
    "reset request without longest hold report")
  `TBHTC_ASSERT_IMP(a_taps_only_on_burst, clk_i, rst_ni,
    out_valid_o && (out_data_o.tap_total != '0), out_data_o.event_code == EV_TAP,
    "tap total set outside a tap burst report")
  `TBHTC_ASSERT_IMP(a_off_wake_exclusive, clk_i, rst_ni,
    out_valid_o && out_data_o.display_off_pulse, !out_data_o.display_wake_pulse,
    "display off and wake in the same result")
  `TBHTC_ASSERT_IMP(a_stall_only_when_full, clk_i, rst_ni,
    !in_ready_o, out_valid_o && !out_ready_i,
    "input stalled while the result register can drain")

endmodule

// ===== src/tbhtc_button.sv =====
// Press/release tracking, hold level and tap burst classification.
module tbhtc_button
  import tbhtc_pkg::*;
#(
  parameter int unsigned TapW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                touch_i,
  input  logic                swallow_i,
  input  cfg_t                cfg_i,
  output logic                burst_o,
  output logic [CODE_W-1:0]   code_o,
  output logic [TAPS_W-1:0]   taps_o,
  output logic                reset_req_o
);

  localparam logic [TapW-1:0] TapMax = {TapW{1'b1}};

  logic              touch_q, touch_d;
  logic              rel_seen_q, rel_seen_d;
  logic [HOLD_W-1:0] press_q, press_d;
  logic [HOLD_W-1:0] rel_q, rel_d;
  logic [TapW-1:0]   tap_q, tap_d;
  logic [CODE_W-1:0] hold_q, hold_d;

  always_comb begin
    touch_d     = touch_q;
    rel_seen_d  = rel_seen_q;
    press_d     = press_q;
    rel_d       = rel_q;
    tap_d       = tap_q;
    hold_d      = hold_q;
    burst_o     = 1'b0;
    code_o      = EV_NONE;
    taps_o      = '0;
    reset_req_o = 1'b0;
    if (touch_i) begin
      rel_seen_d = 1'b0;
      if (!touch_q) begin
        touch_d = 1'b1;
        press_d = '0;
        if (tap_q != TapMax) tap_d = tap_q + 1'b1;
      end else begin
        if (press_q != '1) press_d = press_q + 1'b1;
        // Last threshold passed wins, even when thresholds are out of order.
        if (press_d > cfg_i.hold1_ms) hold_d = EV_HOLD1;
        if (press_d > cfg_i.hold2_ms) hold_d = EV_HOLD2;
        if (press_d > cfg_i.hold3_ms) hold_d = EV_HOLD3;
        if (press_d > cfg_i.hold5_ms) hold_d = EV_HOLD5;
      end
    end else begin
      touch_d = 1'b0;
      if (!rel_seen_q) begin
        rel_seen_d = 1'b1;
        rel_d      = '0;
      end else begin
        if (rel_q != '1) rel_d = rel_q + 1'b1;
        if (rel_d > cfg_i.release_ms) begin
          if (hold_q != EV_NONE) begin
            code_o      = hold_q;
            reset_req_o = (hold_q == EV_HOLD5);
            hold_d      = EV_NONE;
            tap_d       = '0;
          end else if (tap_q != '0) begin
            burst_o = 1'b1;
            tap_d   = '0;
            if (!swallow_i) begin
              code_o = EV_TAP;
              taps_o = TAPS_W'(tap_q);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_q    <= 1'b0;
      rel_seen_q <= 1'b1;
      press_q    <= '0;
      rel_q      <= '0;
      tap_q      <= '0;
      hold_q     <= EV_NONE;
    end else if (step_i) begin
      touch_q    <= touch_d;
      rel_seen_q <= rel_seen_d;
      press_q    <= press_d;
      rel_q      <= rel_d;
      tap_q      <= tap_d;
      hold_q     <= hold_d;
    end
  end

endmodule

// ===== src/tbhtc_timers.sv =====
// Display-off and sleep countdowns, wake edge and burst swallow flag.
module tbhtc_timers
  import tbhtc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         restart_all_i,
  input  logic         restart_sleep_i,
  input  logic         burst_i,
  input  cfg_t         cfg_i,
  output logic         swallow_o,
  output timer_pulse_t pulse_o
);

  logic [DISP_W-1:0]  disp_q, disp_d, disp_ld;
  logic [SLEEP_W-1:0] sleep_q, sleep_d, sleep_ld;
  logic               flag_q, flag_d, flag_ld;
  logic               prev_q;
  logic               swallow_q, swallow_d;
  logic               disp_reload;

  assign disp_reload = restart_all_i | burst_i;

  always_comb begin
    disp_ld   = disp_reload ? cfg_i.display_off_ms : disp_q;
    flag_ld   = disp_reload ? 1'b0 : flag_q;
    sleep_ld  = (disp_reload | restart_sleep_i) ? cfg_i.sleep_ms : sleep_q;
    // A burst consumes the swallow flag before the expiry check can set it again.
    swallow_d = burst_i ? 1'b0 : swallow_q;
    flag_d    = flag_ld;
    pulse_o   = '0;
    if (disp_ld == '0) begin
      disp_d = cfg_i.display_off_ms;
      if (!flag_ld) begin
        flag_d      = 1'b1;
        swallow_d   = 1'b1;
        pulse_o.off = 1'b1;
      end
    end else begin
      disp_d = disp_ld - 1'b1;
    end
    pulse_o.wake = !flag_d && prev_q;
    if (sleep_ld == '0) begin
      sleep_d       = cfg_i.sleep_ms;
      pulse_o.sleep = 1'b1;
    end else begin
      sleep_d = sleep_ld - 1'b1;
    end
  end

  assign swallow_o = swallow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_q    <= DISPOFF_RST;
      sleep_q   <= SLEEP_RST;
      flag_q    <= 1'b0;
      prev_q    <= 1'b1;
      swallow_q <= 1'b0;
    end else if (step_i) begin
      disp_q    <= disp_d;
      sleep_q   <= sleep_d;
      flag_q    <= flag_d;
      prev_q    <= flag_d;
      swallow_q <= swallow_d;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the touch button hold/tap classifier.
module testbench;
  import tbhtc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAP_BITS     = 8;
  localparam int TAP_FIELD    = (1 << TAP_BITS) - 1;
  localparam int TAP_LIMIT    = (TAP_FIELD > 255) ? 255 : TAP_FIELD;
  localparam int SETTLE_TICKS = 4;
  localparam int LONG_STALL   = 60;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int NUM_PHASES   = 6;

  // Index past the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    in_item_t  tick;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_item_t            out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;

  touch_button_hold_tap_classifier #(
    .TAP_COUNT_BITS(TAP_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Classifier state mirror
  cfg_t               model_cfg;
  logic               pressed;
  logic               released;
  logic [HOLD_W-1:0]  press_ms;
  logic [HOLD_W-1:0]  quiet_ms;
  logic [TAPS_W-1:0]  tap_cnt;
  logic [CODE_W-1:0]  hold_lvl;
  logic [DISP_W-1:0]  disp_cnt;
  logic [SLEEP_W-1:0] sleep_cnt;
  logic               disp_off;
  logic               disp_off_prev;
  logic               swallow;

  out_item_t pending_out[$];
  in_item_t  tick_plan[$];
  dir_row_t  dir_rows[$];

  int fails       = 0;
  int ticks_sent  = 0;
  int phase_sent  = 0;
  int phase_no    = -1;
  int burst_left  = 0;
  int cycle_count = 0;
  int checked     = 0;
  int tap_events  = 0;
  int hold_events = 0;
  int reset_reqs  = 0;
  int off_pulses  = 0;
  int wake_pulses = 0;
  int sleep_hits  = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void reset_model();
    model_cfg.hold1_ms       = HOLD1_RST;
    model_cfg.hold2_ms       = HOLD2_RST;
    model_cfg.hold3_ms       = HOLD3_RST;
    model_cfg.hold5_ms       = HOLD5_RST;
    model_cfg.release_ms     = RELEASE_RST;
    model_cfg.display_off_ms = DISPOFF_RST;
    model_cfg.sleep_ms       = SLEEP_RST;
    pressed       = 1'b0;
    released      = 1'b1;
    press_ms      = '0;
    quiet_ms      = '0;
    tap_cnt       = '0;
    hold_lvl      = EV_NONE;
    disp_cnt      = DISPOFF_RST;
    sleep_cnt     = SLEEP_RST;
    disp_off      = 1'b0;
    disp_off_prev = 1'b1;
    swallow       = 1'b0;
  endfunction

  function automatic void store_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    case (idx)
      REG_HOLD1:   model_cfg.hold1_ms       = val[HOLD_W-1:0];
      REG_HOLD2:   model_cfg.hold2_ms       = val[HOLD_W-1:0];
      REG_HOLD3:   model_cfg.hold3_ms       = val[HOLD_W-1:0];
      REG_HOLD5:   model_cfg.hold5_ms       = val[HOLD_W-1:0];
      REG_RELEASE: model_cfg.release_ms     = val[HOLD_W-1:0];
      REG_DISPOFF: model_cfg.display_off_ms = val[DISP_W-1:0];
      REG_SLEEP:   model_cfg.sleep_ms       = val[SLEEP_W-1:0];
      default: ;
    endcase
  endfunction

  // One millisecond tick: restarts, button, display countdown, wake, sleep.
  function automatic out_item_t classify_tick(in_item_t t);
    out_item_t r;
    r = '0;
    if (t.restart_all) begin
      disp_cnt  = model_cfg.display_off_ms;
      sleep_cnt = model_cfg.sleep_ms;
      disp_off  = 1'b0;
    end
    if (t.restart_sleep) sleep_cnt = model_cfg.sleep_ms;

    if (t.touch_level) begin
      released = 1'b0;
      if (!pressed) begin
        pressed  = 1'b1;
        press_ms = '0;
        if (tap_cnt < TAP_LIMIT) tap_cnt++;
      end else begin
        if (press_ms != '1) press_ms++;
        // later thresholds win, even when out of order
        if (press_ms > model_cfg.hold1_ms) hold_lvl = EV_HOLD1;
        if (press_ms > model_cfg.hold2_ms) hold_lvl = EV_HOLD2;
        if (press_ms > model_cfg.hold3_ms) hold_lvl = EV_HOLD3;
        if (press_ms > model_cfg.hold5_ms) hold_lvl = EV_HOLD5;
      end
    end else begin
      pressed = 1'b0;
      if (!released) begin
        released = 1'b1;
        quiet_ms = '0;
      end else begin
        if (quiet_ms != '1) quiet_ms++;
        if (quiet_ms > model_cfg.release_ms) begin
          if (hold_lvl != EV_NONE) begin
            r.event_code    = hold_lvl;
            r.reset_request = (hold_lvl == EV_HOLD5);
            hold_lvl        = EV_NONE;
            tap_cnt         = '0;
          end else if (tap_cnt != '0) begin
            disp_cnt  = model_cfg.display_off_ms;
            sleep_cnt = model_cfg.sleep_ms;
            disp_off  = 1'b0;
            if (swallow) begin
              swallow = 1'b0;
            end else begin
              r.event_code = EV_TAP;
              r.tap_total  = tap_cnt;
            end
            tap_cnt = '0;
          end
        end
      end
    end

    if (disp_cnt == '0) begin
      disp_cnt = model_cfg.display_off_ms;
      if (!disp_off) begin
        disp_off            = 1'b1;
        swallow             = 1'b1;
        r.display_off_pulse = 1'b1;
      end
    end else begin
      disp_cnt--;
    end

    r.display_wake_pulse = !disp_off && disp_off_prev;
    disp_off_prev        = disp_off;

    if (sleep_cnt == '0) begin
      sleep_cnt     = model_cfg.sleep_ms;
      r.sleep_pulse = 1'b1;
    end else begin
      sleep_cnt--;
    end
    return r;
  endfunction

  function automatic out_item_t known_out(logic [CODE_W-1:0] code, logic [TAPS_W-1:0] taps,
                                          logic rst_req, logic wake);
    out_item_t r;
    r                    = '0;
    r.event_code         = code;
    r.tap_total          = taps;
    r.reset_request      = rst_req;
    r.display_wake_pulse = wake;
    return r;
  endfunction

  function automatic void add_row(logic touch, logic ra, logic rs, logic typed, out_item_t want);
    dir_row_t row;
    row.tick.touch_level   = touch;
    row.tick.restart_all   = ra;
    row.tick.restart_sleep = rs;
    row.typed              = typed;
    row.want               = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void plan_tick(logic touch, logic keep_awake);
    in_item_t t;
    t.touch_level   = touch;
    t.restart_all   = keep_awake | ($urandom_range(0, 127) == 0);
    t.restart_sleep = ($urandom_range(0, 127) == 0);
    tick_plan.push_back(t);
  endfunction

  function automatic cfg_t pick_settings(int p);
    cfg_t c;
    c.hold1_ms       = HOLD_W'($urandom_range(1, 10));
    c.hold2_ms       = c.hold1_ms + HOLD_W'($urandom_range(1, 6));
    c.hold3_ms       = c.hold2_ms + HOLD_W'($urandom_range(1, 6));
    c.hold5_ms       = c.hold3_ms + HOLD_W'($urandom_range(1, 8));
    c.release_ms     = HOLD_W'($urandom_range(0, 5));
    c.display_off_ms = DISP_W'($urandom_range(30, 250));
    c.sleep_ms       = SLEEP_W'($urandom_range(20, 120));
    case (p)
      2: begin
        c.hold1_ms       = '0;
        c.hold2_ms       = '0;
        c.hold3_ms       = '0;
        c.hold5_ms       = '0;
        c.release_ms     = '0;
        c.display_off_ms = DISP_W'(1);
        c.sleep_ms       = SLEEP_W'(1);
      end
      3: begin
        c.hold1_ms       = HOLD_W'($urandom_range(15, 25));
        c.hold2_ms       = HOLD_W'($urandom_range(1, 5));
        c.hold3_ms       = HOLD_W'($urandom_range(9, 14));
        c.hold5_ms       = HOLD_W'($urandom_range(6, 8));
        c.release_ms     = HOLD_W'($urandom_range(1, 3));
        c.display_off_ms = DISP_W'($urandom_range(20, 60));
        c.sleep_ms       = SLEEP_W'($urandom_range(1, 3));
      end
      4: begin
        c.hold1_ms       = '1;
        c.hold2_ms       = '1;
        c.hold3_ms       = '1;
        c.hold5_ms       = '1;
        c.release_ms     = '1;
        c.display_off_ms = '1;
        c.sleep_ms       = '1;
      end
      5: begin
        c.release_ms     = HOLD_W'($urandom_range(0, 1));
        c.display_off_ms = DISP_W'($urandom_range(400, 600));
      end
      default: ;
    endcase
    return c;
  endfunction

  // Well-formed presses and tap bursts with random content, plus some noise, idle gaps and an optional tap storm.
  task automatic plan_phase(int n_items, bit with_storm);
    int longest, lim, rel, k, n, j;
    longest = int'(model_cfg.hold1_ms);
    if (int'(model_cfg.hold2_ms) > longest) longest = int'(model_cfg.hold2_ms);
    if (int'(model_cfg.hold3_ms) > longest) longest = int'(model_cfg.hold3_ms);
    if (int'(model_cfg.hold5_ms) > longest) longest = int'(model_cfg.hold5_ms);
    lim = (longest > 57) ? 60 : longest + 3;
    rel = (int'(model_cfg.release_ms) > 30) ? 30 : int'(model_cfg.release_ms);
    while (tick_plan.size() < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          k = $urandom_range(1, 5);
          repeat (k) begin
            repeat ($urandom_range(1, 3)) plan_tick(1'b1, 1'b0);
            repeat ($urandom_range(1, rel + 1)) plan_tick(1'b0, 1'b0);
          end
          repeat ($urandom_range(rel + 2, rel + 6)) plan_tick(1'b0, 1'b0);
        end
        4, 5, 6, 7: begin
          repeat ($urandom_range(1, lim)) plan_tick(1'b1, 1'b0);
          repeat ($urandom_range(rel + 2, rel + 6)) plan_tick(1'b0, 1'b0);
        end
        8: repeat ($urandom_range(20, 80)) plan_tick(1'b0, 1'b0);
        default: repeat ($urandom_range(1, 8)) plan_tick(1'($urandom_range(0, 1)), 1'b0);
      endcase
    end
    if (with_storm) begin
      // flush any pending report, use up a pending swallow, then saturate the tap count
      repeat (rel + 2) plan_tick(1'b0, 1'b0);
      plan_tick(1'b1, 1'b1);
      repeat (rel + 2) plan_tick(1'b0, 1'b0);
      n = $urandom_range(270, 300);
      for (j = 0; j < n; j++) begin
        plan_tick(1'b1, (j % 16) == 0);
        plan_tick(1'b0, 1'b0);
      end
      repeat (rel + 2) plan_tick(1'b0, 1'b0);
    end
  endtask

  task automatic send_tick(in_item_t t, logic typed, out_item_t want);
    out_item_t predicted;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 20 : 4)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    ticks_sent++;
    phase_sent++;
    predicted = classify_tick(t);
    pending_out.push_back(typed ? want : predicted);
  endtask

  // Drop valid, wait for every result, then let the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_settings(cfg_t c);
    logic [CFG_DAT_W-1:0] vals [8];
    logic [CFG_IDX_W-1:0] idx;
    int                   n;
    vals[REG_HOLD1]   = CFG_DAT_W'(c.hold1_ms);
    vals[REG_HOLD2]   = CFG_DAT_W'(c.hold2_ms);
    vals[REG_HOLD3]   = CFG_DAT_W'(c.hold3_ms);
    vals[REG_HOLD5]   = CFG_DAT_W'(c.hold5_ms);
    vals[REG_RELEASE] = CFG_DAT_W'(c.release_ms);
    vals[REG_DISPOFF] = CFG_DAT_W'(c.display_off_ms);
    vals[REG_SLEEP]   = c.sleep_ms;
    vals[REG_UNUSED]  = CFG_DAT_W'($urandom);
    for (n = 0; n < 8; n++) begin
      idx = n[CFG_IDX_W-1:0];
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= vals[idx];
      @(posedge clk_i);
      store_setting(idx, vals[idx]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_out.size() == 0) begin
      $error("result with nothing pending: %h", got);
      fails++;
      return;
    end
    want = pending_out.pop_front();
    checked++;
    if (got.event_code != want.event_code) begin
      $error("event_code: expected %0d, got %0d", want.event_code, got.event_code);
      fails++;
    end
    if (got.tap_total != want.tap_total) begin
      $error("tap_total: expected %0d, got %0d", want.tap_total, got.tap_total);
      fails++;
    end
    if (got.reset_request != want.reset_request) begin
      $error("reset_request: expected %0b, got %0b", want.reset_request, got.reset_request);
      fails++;
    end
    if (got.display_off_pulse != want.display_off_pulse) begin
      $error("display_off_pulse: expected %0b, got %0b",
             want.display_off_pulse, got.display_off_pulse);
      fails++;
    end
    if (got.display_wake_pulse != want.display_wake_pulse) begin
      $error("display_wake_pulse: expected %0b, got %0b",
             want.display_wake_pulse, got.display_wake_pulse);
      fails++;
    end
    if (got.sleep_pulse != want.sleep_pulse) begin
      $error("sleep_pulse: expected %0b, got %0b", want.sleep_pulse, got.sleep_pulse);
      fails++;
    end
    if (got.event_code == EV_TAP) tap_events++;
    if (got.event_code >= EV_HOLD1) hold_events++;
    reset_reqs  += got.reset_request;
    off_pulses  += got.display_off_pulse;
    wake_pulses += got.display_wake_pulse;
    sleep_hits  += got.sleep_pulse;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_data_o);
  end

  // Result side: stall patterns that change now and then, plus one long hold-off.
  initial begin
    int  mode;
    int  span;
    bit  stall_done;
    mode        = 0;
    span        = 0;
    stall_done  = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!stall_done && phase_no == 1 && phase_sent >= 40) begin
        stall_done  = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
      end
      span--;
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (span % 5) < 2;
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    cfg_t plan;
    int   i;
    int   p;
    int   split_at;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short thresholds so every hold level is reached within a few ticks.
    plan.hold1_ms       = '0;
    plan.hold2_ms       = HOLD_W'(1);
    plan.hold3_ms       = HOLD_W'(2);
    plan.hold5_ms       = HOLD_W'(3);
    plan.release_ms     = '0;
    plan.display_off_ms = DISPOFF_RST;
    plan.sleep_ms       = SLEEP_RST;
    write_settings(plan);

    add_row(1'b0, 1'b0, 1'b0, 1'b1, known_out(EV_NONE, 8'd0, 1'b0, 1'b1));
    add_row(1'b1, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 1'b0, 1'b0, 1'b1, known_out(EV_TAP, 8'd1, 1'b0, 1'b0));
    repeat (5) add_row(1'b1, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 1'b0, 1'b0, 1'b1, known_out(EV_HOLD5, 8'd0, 1'b1, 1'b0));
    repeat (2) add_row(1'b1, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 1'b0, 1'b0, 1'b1, known_out(EV_HOLD1, 8'd0, 1'b0, 1'b0));
    repeat (3) add_row(1'b1, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b0, 1'b0, 1'b0, 1'b1, known_out(EV_HOLD2, 8'd0, 1'b0, 1'b0));
    split_at = dir_rows.size();
    // Fastest timers: display off, swallowed burst, wake, sleep every other tick.
    add_row(1'b0, 1'b1, 1'b1, 1'b0, '0);
    add_row(1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b1, 1'b0, 1'b1, 1'b0, '0);
    repeat (2) add_row(1'b0, 1'b0, 1'b0, 1'b0, '0);
    add_row(1'b1, 1'b1, 1'b0, 1'b0, '0);
    repeat (2) add_row(1'b0, 1'b0, 1'b0, 1'b0, '0);

    for (i = 0; i < dir_rows.size(); i++) begin
      if (i == split_at) begin
        settle();
        plan.display_off_ms = DISP_W'(1);
        plan.sleep_ms       = SLEEP_W'(1);
        write_settings(plan);
      end
      send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      phase_sent = 0;
      phase_no   = p;
      plan       = pick_settings(p);
      write_settings(plan);
      plan_phase((p == 4) ? 150 : (p == 2) ? 250 : 300, p == 5);
      while (tick_plan.size() != 0) send_tick(tick_plan.pop_front(), 1'b0, '0);
    end
    settle();

    $display("summary: %0d ticks over %0d register settings, %0d results checked",
             ticks_sent, NUM_PHASES + 2, checked);
    $display("summary: %0d tap bursts, %0d hold reports (%0d reset requests) in %0d cycles",
             tap_events, hold_events, reset_reqs, cycle_count);
    $display("summary: %0d display off, %0d wake, %0d sleep pulses",
             off_pulses, wake_pulses, sleep_hits);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
